/* rtl/trpd_pkg.sv */
// ============================================================================
// trpd_pkg
// Shared types and constants of the TGA run-length packet decoder.
// ============================================================================
`default_nettype none

package trpd_pkg;

  // Widths of stream fields and registers.
  localparam int unsigned ByteW       = 8;
  localparam int unsigned PixelW      = 32;
  localparam int unsigned BppW        = 3;
  localparam int unsigned CountW      = 8;
  localparam int unsigned IdxW        = 2;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned ValidW      = 2;
  localparam int unsigned OutDataW    = 2 * PixelW;
  localparam int unsigned OutUserW    = ValidW + 1;

  // Largest pixel size in bytes.
  localparam logic [BppW-1:0] MaxBytesPerPixel = 3'd4;

  // Header byte fields.
  localparam logic [ByteW-1:0] RunFlag   = 8'h80;
  localparam logic [ByteW-1:0] CountMask = 8'h7F;

  // Reset values of the configuration registers.
  localparam logic [BppW-1:0]     BppReset   = 3'd3;
  localparam logic [CfgDataW-1:0] FrameReset = 32'd1;

  // Pixel counts carried in a result.
  localparam logic [ValidW-1:0] OnePixel  = 2'd1;
  localparam logic [ValidW-1:0] TwoPixels = 2'd2;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_BYTES_PER_PIXEL = 1'b0,
    REG_FRAME_PIXELS    = 1'b1
  } cfg_reg_e;

  // Packet phase of the controller.
  typedef enum logic [1:0] {
    ST_HEADER,
    ST_DATA,
    ST_DISCARD,
    ST_RUN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;  // input side may take a byte
    logic load_hdr;  // header byte accepted
    logic take_byte; // pixel byte accepted
    logic emit_raw;  // raw pixel completes and leaves as one result
    logic start_run; // run pixel completes and is held for emission
    logic dec_left;  // one pixel of the packet is finished
    logic emit_run;  // one run result leaves
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
    logic pix_done;  // the byte at the input completes a pixel
    logic is_run;    // current packet is a run packet
    logic left_one;  // the current pixel is the last of the packet
    logic fe_next;   // the next counted pixel closes the image
    logic run_last;  // the run result of this cycle is the final one
  } sts_t;

endpackage

`default_nettype wire

/* rtl/trpd_ctrl.sv */
// ============================================================================
// trpd_ctrl
// Packet phase state machine: header, pixel data, discard and run emission.
// ============================================================================
`default_nettype none

module trpd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire trpd_pkg::sts_t sts_i,
  output trpd_pkg::cmd_t     cmd_o
);
  import trpd_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HEADER;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    accept  = 1'b0;
    unique case (state_q)
      ST_HEADER: begin
        cmd_o.in_ready = sts_i.out_free;
        accept         = in_valid_i && sts_i.out_free;
        cmd_o.load_hdr = accept;
        if (accept) begin
          state_d = ST_DATA;
        end
      end
      ST_DATA: begin
        cmd_o.in_ready  = sts_i.out_free;
        accept          = in_valid_i && sts_i.out_free;
        cmd_o.take_byte = accept;
        if (accept && sts_i.pix_done) begin
          if (sts_i.is_run) begin
            cmd_o.start_run = 1'b1;
            state_d         = ST_RUN;
          end else begin
            cmd_o.emit_raw = 1'b1;
            cmd_o.dec_left = 1'b1;
            if (sts_i.left_one) begin
              state_d = ST_HEADER;
            end else if (sts_i.fe_next) begin
              state_d = ST_DISCARD;
            end
          end
        end
      end
      ST_DISCARD: begin
        cmd_o.in_ready  = sts_i.out_free;
        accept          = in_valid_i && sts_i.out_free;
        cmd_o.take_byte = accept;
        if (accept && sts_i.pix_done) begin
          cmd_o.dec_left = 1'b1;
          if (sts_i.left_one) begin
            state_d = ST_HEADER;
          end
        end
      end
      ST_RUN: begin
        cmd_o.emit_run = sts_i.out_free;
        if (sts_i.out_free && sts_i.run_last) begin
          state_d = ST_HEADER;
        end
      end
      default: begin
        state_d = ST_HEADER;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/trpd_datapath.sv */
// ============================================================================
// trpd_datapath
// Configuration, pixel assembly, packet and image counters, output register.
// ============================================================================
`default_nettype none

module trpd_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [trpd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [trpd_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  wire logic [trpd_pkg::ByteW-1:0]      in_byte_i,
  input  wire trpd_pkg::cmd_t                  cmd_i,
  output trpd_pkg::sts_t                       sts_o,
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output logic [trpd_pkg::OutDataW-1:0]        out_data_o,
  output logic [trpd_pkg::OutUserW-1:0]        out_user_o,
  output logic                                 out_last_o
);
  import trpd_pkg::*;

  // Configuration registers.
  logic [BppW-1:0]     bpp_q;
  logic [CfgDataW-1:0] frame_q;

  // Packet and pixel state.
  logic              run_q;
  logic [CountW-1:0] left_q;
  logic [IdxW-1:0]   idx_q;
  logic [PixelW-1:0] asm_q;
  logic [PixelW-1:0] run_px_q;
  logic [CountW-1:0] run_n_q;
  logic [PixelW-1:0] cnt_q, cnt_d;

  // Output register.
  logic              ov_q, ov_d;
  logic [PixelW-1:0] first_q, second_q;
  logic [ValidW-1:0] pv_q;
  logic              last_q, fend_q;

  logic [BppW-1:0]   bpp_eff;
  logic [BppW-1:0]   idx_inc;
  logic              pix_done;
  logic [PixelW-1:0] px_cur;
  logic [PixelW-1:0] cnt_p1, cnt_p2;
  logic              fe1, fe2;
  logic              run_single;
  logic              run_last;

  // Effective pixel size: zero acts as one, large values saturate.
  always_comb begin
    bpp_eff = bpp_q;
    if (bpp_q == '0) begin
      bpp_eff = BppW'(1);
    end else if (bpp_q > MaxBytesPerPixel) begin
      bpp_eff = MaxBytesPerPixel;
    end
  end

  // Byte gathering: the pixel is complete once the byte count reaches its size.
  assign idx_inc  = BppW'(idx_q) + BppW'(1);
  assign pix_done = (idx_inc >= bpp_eff);
  assign px_cur   = asm_q | (PixelW'(in_byte_i) << {idx_q, 3'b000});

  // Image pixel count for one or two more pixels.
  assign cnt_p1 = cnt_q + PixelW'(1);
  assign cnt_p2 = cnt_q + PixelW'(2);
  assign fe1    = (cnt_p1 == frame_q);
  assign fe2    = (cnt_p2 == frame_q);

  // A run result carries one pixel when the image closes or one pixel remains.
  assign run_single = fe1 || (run_n_q == CountW'(1));
  assign run_last   = run_single || fe2 || (run_n_q == CountW'(2));

  // Status toward the controller.
  always_comb begin
    sts_o          = '0;
    sts_o.out_free = !ov_q || out_ready_i;
    sts_o.pix_done = pix_done;
    sts_o.is_run   = run_q;
    sts_o.left_one = (left_q <= CountW'(1));
    sts_o.fe_next  = fe1;
    sts_o.run_last = run_last;
  end

  // Next image count.
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.emit_raw || (cmd_i.emit_run && run_single)) begin
      cnt_d = fe1 ? '0 : cnt_p1;
    end else if (cmd_i.emit_run) begin
      cnt_d = fe2 ? '0 : cnt_p2;
    end
  end

  // Output valid flag.
  always_comb begin
    ov_d = ov_q;
    if (cmd_i.emit_raw || cmd_i.emit_run) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q   <= BppReset;
      frame_q <= FrameReset;
      run_q   <= 1'b0;
      left_q  <= '0;
      idx_q   <= '0;
      asm_q   <= '0;
      run_n_q <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      ov_q  <= ov_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_BYTES_PER_PIXEL: bpp_q   <= cfg_wdata_i[BppW-1:0];
          REG_FRAME_PIXELS:    frame_q <= cfg_wdata_i;
          default:             ;
        endcase
      end
      if (cmd_i.load_hdr) begin
        run_q  <= (in_byte_i & RunFlag) != '0;
        left_q <= CountW'(in_byte_i & CountMask) + CountW'(1);
        idx_q  <= '0;
        asm_q  <= '0;
      end else if (cmd_i.take_byte) begin
        if (pix_done) begin
          idx_q <= '0;
          asm_q <= '0;
        end else begin
          idx_q <= idx_inc[IdxW-1:0];
          asm_q <= px_cur;
        end
      end
      if (cmd_i.dec_left) begin
        left_q <= left_q - CountW'(1);
      end
      if (cmd_i.start_run) begin
        run_n_q <= left_q;
      end else if (cmd_i.emit_run) begin
        run_n_q <= run_n_q - (run_single ? CountW'(1) : CountW'(2));
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_run) begin
      run_px_q <= px_cur;
    end
    if (cmd_i.emit_raw) begin
      first_q  <= px_cur;
      second_q <= '0;
      pv_q     <= OnePixel;
      last_q   <= 1'b1;
      fend_q   <= fe1;
    end else if (cmd_i.emit_run) begin
      first_q  <= run_px_q;
      second_q <= run_single ? '0 : run_px_q;
      pv_q     <= run_single ? OnePixel : TwoPixels;
      last_q   <= run_last;
      fend_q   <= run_single ? fe1 : fe2;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = {second_q, first_q};
  assign out_user_o  = {fend_q, pv_q};
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

/* rtl/tga_rle_packet_decoder_top.sv */
// ============================================================================
// tga_rle_packet_decoder_top
// TGA run-length packet decoder: compressed bytes in, pixel pairs out.
// ============================================================================
// Throughput: one stream byte per cycle while no run is being emitted and the
// output register is free. A raw pixel result appears in the cycle after its
// last byte is taken. A run pixel is held in a register and emitted from the
// run state; the run stalls the input, one output register slot per result.
// Reset: asynchronous, active low; clears packet state and the pixel count,
// sets bytes_per_pixel to 3 and frame_pixels to 1.
`default_nettype none

module tga_rle_packet_decoder_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration write port.
  input  wire logic                                cfg_we_i,
  input  wire logic [trpd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [trpd_pkg::CfgDataW-1:0]       cfg_wdata_i,
  // Input stream.
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  input  wire logic [trpd_pkg::ByteW-1:0]          s_axis_tdata_i,   // stream_byte
  // Output stream.
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  output logic [trpd_pkg::OutDataW-1:0]            m_axis_tdata_o,   // first_pixel, second_pixel
  output logic                                     m_axis_tlast_o,   // last_of_burst
  output logic [trpd_pkg::OutUserW-1:0]            m_axis_tuser_o    // pixels_valid, frame_end
);
  import trpd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Packet phase controller.
  trpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Pixel datapath and output register.
  trpd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_byte_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

  assign s_axis_tready_o = cmd.in_ready;

endmodule

`default_nettype wire

/* dv/tb_tga_rle_packet_decoder_top.sv */
// ============================================================================
// tb_tga_rle_packet_decoder_top
// Self-checking testbench for the TGA run-length packet decoder.
// ============================================================================
// Stream bytes go in one transaction at a time. A behavioral decoder in this
// file follows every accepted byte and queues the pixel results it implies.
// Each output transaction is checked against the oldest queued result. The
// directed tests cover reset defaults, frame ends inside runs and raw packets,
// pixel sizes and their clamping, and a pixel size change in mid-pixel. Random
// packets then run under four idling patterns on the two stream sides.

module tb_tga_rle_packet_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import trpd_pkg::*;

  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxShown    = 10;
  localparam int unsigned SegItems    = 20;
  localparam int unsigned NumSegs     = 8;

  // One pixel result as it leaves the output stream.
  typedef struct packed {
    logic [PixelW-1:0] first_px;
    logic [PixelW-1:0] second_px;
    logic [ValidW-1:0] npix;
    logic              burst_last;
    logic              frame_end;
  } pix_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [ByteW-1:0]    s_axis_tdata_i;    // stream_byte
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;    // first_pixel, second_pixel
  logic                m_axis_tlast_o;    // last_of_burst
  logic [OutUserW-1:0] m_axis_tuser_o;    // pixels_valid, frame_end

  tga_rle_packet_decoder_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Pixel results still owed by the block, oldest first.
  pix_result_t expected_q[$];

  // Register copies and packet state of the behavioral decoder.
  logic [BppW-1:0]     cfg_bpp;
  logic [CfgDataW-1:0] cfg_frame;
  state_e              pkt_phase;
  logic                pkt_run;
  int unsigned         pix_left;
  logic [3:0]          byte_cnt;
  logic [PixelW-1:0]   pix_acc;
  logic [PixelW-1:0]   pix_emitted;

  int unsigned error_count;
  int unsigned bytes_sent;
  int unsigned results_seen;
  int unsigned reg_writes;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #40ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= MaxShown) $display("%0t ERROR: %s", $realtime, msg);
  endfunction

  function automatic string fmt_result(input pix_result_t r);
    return $sformatf("px0=%08h px1=%08h npix=%0d last=%0b fend=%0b",
                     r.first_px, r.second_px, r.npix, r.burst_last, r.frame_end);
  endfunction

  // Out-of-range sizes clamp to the nearest legal one.
  function automatic int unsigned bytes_per_px();
    if (cfg_bpp == '0) return 1;
    if (cfg_bpp > MaxBytesPerPixel) return MaxBytesPerPixel;
    return cfg_bpp;
  endfunction

  // Counts one emitted pixel; returns 1 when it closes the image.
  function automatic logic tally_pixel();
    pix_emitted = pix_emitted + 1'b1;
    if (pix_emitted == cfg_frame) begin
      pix_emitted = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the behavioral decoder by one accepted byte.
  task automatic decode_byte(input logic [ByteW-1:0] b);
    int unsigned bpp;
    int unsigned remaining;
    int unsigned added;
    logic [PixelW-1:0] px;
    logic fe;
    pix_result_t res;
    bpp = bytes_per_px();
    added = 0;
    if (pkt_phase == ST_HEADER) begin
      pkt_run   = (b & RunFlag) != '0;
      pix_left  = int'(b & CountMask) + 1;
      byte_cnt  = '0;
      pix_acc   = '0;
      pkt_phase = ST_DATA;
      return;
    end
    // Gather the pixel bytes, first byte lowest.
    if (byte_cnt < 4) pix_acc |= PixelW'(b) << (8 * byte_cnt);
    byte_cnt = byte_cnt + 1'b1;
    if (byte_cnt < bpp) return;
    px       = pix_acc;
    byte_cnt = '0;
    pix_acc  = '0;
    // After a frame end the rest of a raw packet is swallowed.
    if (pkt_phase == ST_DISCARD) begin
      if (pix_left > 0) pix_left--;
      if (pix_left == 0) pkt_phase = ST_HEADER;
      return;
    end
    if (pkt_run) begin
      // A run leaves in pairs until the count or the image runs out.
      remaining = pix_left;
      while (remaining > 0) begin
        res          = '0;
        res.first_px = px;
        res.npix     = OnePixel;
        fe           = tally_pixel();
        remaining--;
        if (!fe && remaining > 0) begin
          fe            = tally_pixel();
          remaining--;
          res.npix      = TwoPixels;
          res.second_px = px;
        end
        res.frame_end = fe;
        expected_q.push_back(res);
        added++;
        if (fe) break;
      end
      pix_left  = 0;
      pkt_phase = ST_HEADER;
    end else begin
      res           = '0;
      res.first_px  = px;
      res.npix      = OnePixel;
      res.frame_end = tally_pixel();
      expected_q.push_back(res);
      added++;
      if (pix_left > 0) pix_left--;
      if (pix_left == 0) pkt_phase = ST_HEADER;
      else if (res.frame_end) pkt_phase = ST_DISCARD;
    end
    if (added > 0) expected_q[$].burst_last = 1'b1;
  endtask

  // Sends one byte as an input transaction, with random gaps before it.
  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    decode_byte(b);
    bytes_sent++;
  endtask

  // Register write; only called after wait_idle, once every owed result has left.
  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_BYTES_PER_PIXEL: cfg_bpp = val[BppW-1:0];
      REG_FRAME_PIXELS:    cfg_frame = val;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  // Drops the input valid and waits until every owed result has left.
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // Output side: check each transaction, then pick the next ready.
  always @(posedge clk_i) begin : result_check
    pix_result_t got;
    pix_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.first_px   = m_axis_tdata_o[PixelW-1:0];
      got.second_px  = m_axis_tdata_o[2*PixelW-1:PixelW];
      got.npix       = m_axis_tuser_o[ValidW-1:0];
      got.frame_end  = m_axis_tuser_o[ValidW];
      got.burst_last = m_axis_tlast_o;
      results_seen++;
      if (expected_q.size() == 0) begin
        note_error({"unexpected result ", fmt_result(got)});
      end else begin
        want = expected_q.pop_front();
        if (got.first_px !== want.first_px || got.second_px !== want.second_px ||
            got.npix !== want.npix || got.burst_last !== want.burst_last ||
            got.frame_end !== want.frame_end)
          note_error({"mismatch: expected ", fmt_result(want), " actual ", fmt_result(got)});
      end
    end
    m_axis_tready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Reset defaults: 3-byte pixels, one-pixel images, a run cut by the frame end.
  task automatic test_reset_defaults();
    set_idling(0, 0);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'h81);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
  endtask

  // A frame end inside a raw packet swallows the rest of that packet.
  task automatic test_raw_frame_end();
    wait_idle();
    write_reg(REG_BYTES_PER_PIXEL, 32'd1);
    write_reg(REG_FRAME_PIXELS, 32'd2);
    send_byte(8'h03);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(8'h44);
  endtask

  // Longest run, a zero size acting as one byte and an oversize acting as four.
  task automatic test_pixel_widths();
    wait_idle();
    write_reg(REG_FRAME_PIXELS, 32'hFFFF_FFFF);
    send_byte(8'hFF);
    send_byte(8'hA5);
    wait_idle();
    write_reg(REG_BYTES_PER_PIXEL, 32'd0);
    send_byte(8'h80);
    send_byte(8'h00);
    wait_idle();
    write_reg(REG_BYTES_PER_PIXEL, 32'd7);
    send_byte(8'h82);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
  endtask

  // Shrinking the pixel size to no more than the bytes already gathered ends the
  // pixel on the next byte.
  task automatic test_bpp_change_mid_pixel();
    wait_idle();
    write_reg(REG_BYTES_PER_PIXEL, 32'd4);
    send_byte(8'h00);
    send_byte(8'h12);
    send_byte(8'h34);
    wait_idle();
    write_reg(REG_BYTES_PER_PIXEL, 32'd2);
    send_byte(8'h56);
  endtask

  // One random packet: mostly well formed, some noise bytes and cut packets.
  task automatic send_packet();
    int unsigned bpp;
    int unsigned count;
    int unsigned nbytes;
    logic run;
    bpp = bytes_per_px();
    if ($urandom_range(0, 7) == 0) begin
      send_byte(ByteW'($urandom));
      return;
    end
    run = $urandom_range(0, 1);
    if (run) count = ($urandom_range(0, 5) == 0) ? $urandom_range(64, 127) : $urandom_range(0, 9);
    else count = $urandom_range(0, 5);
    send_byte({run, 7'(count)});
    nbytes = run ? bpp : (count + 1) * bpp;
    if ($urandom_range(0, 9) == 0) nbytes = $urandom_range(0, nbytes - 1);
    repeat (nbytes) send_byte(ByteW'($urandom));
  endtask

  // Random packets in segments, each with its own settings and idling.
  task automatic test_random_traffic();
    int unsigned seg_end;
    logic [CfgDataW-1:0] frame;
    for (int seg = 0; seg < NumSegs; seg++) begin
      wait_idle();
      case (seg / 2)
        0: set_idling(0, 0);
        1: set_idling(83, 0);
        2: set_idling(0, 83);
        default: set_idling(37, 37);
      endcase
      case (seg)
        0: write_reg(REG_BYTES_PER_PIXEL, 32'd1);
        1: write_reg(REG_BYTES_PER_PIXEL, 32'd4);
        default: write_reg(REG_BYTES_PER_PIXEL, CfgDataW'($urandom_range(0, 7)));
      endcase
      // Image sizes mostly just past the running count make frame ends frequent.
      case (seg)
        2: frame = '0;
        5: frame = 32'hFFFE_0001;
        default: frame = pix_emitted + $urandom_range(1, 12);
      endcase
      write_reg(REG_FRAME_PIXELS, frame);
      seg_end = bytes_sent + SegItems;
      while (bytes_sent < seg_end) send_packet();
    end
  endtask

  // Test sequence.
  initial begin : main_seq
    int unsigned guard;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= REG_BYTES_PER_PIXEL;
    cfg_wdata_i     <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    cfg_bpp      = BppReset;
    cfg_frame    = FrameReset;
    pkt_phase    = ST_HEADER;
    pkt_run      = 1'b0;
    pix_left     = 0;
    byte_cnt     = '0;
    pix_acc      = '0;
    pix_emitted  = '0;
    error_count  = 0;
    bytes_sent   = 0;
    results_seen = 0;
    reg_writes   = 0;
    set_idling(0, 0);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_raw_frame_end();
    test_pixel_widths();
    test_bpp_change_mid_pixel();
    test_random_traffic();

    // Drain what is still owed, within a bound.
    s_axis_tvalid_i <= 1'b0;
    guard = 0;
    while (expected_q.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_q.size() != 0)
      note_error($sformatf("%0d expected results never arrived", expected_q.size()));

    $display("Summary: %0d stream bytes sent, %0d pixel results checked, %0d register writes.",
             bytes_sent, results_seen, reg_writes);
    $display("Summary: directed packet cases, then random packets under four idling patterns.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* tga_rle_packet_decoder_top.f */
rtl/trpd_pkg.sv
rtl/trpd_ctrl.sv
rtl/trpd_datapath.sv
rtl/tga_rle_packet_decoder_top.sv
dv/tb_tga_rle_packet_decoder_top.sv
